### sv/cci_pkg.sv
// Shared types for the circle-circle intersection block.
// Holds the query, result and internal job words; no dependencies.
`default_nettype none
package cci_pkg;

  typedef struct packed {
    logic [31:0] origin_radius;
    logic [31:0] center_offset;
    logic [31:0] second_radius;
  } cci_in_t;

  typedef struct packed {
    logic signed [32:0] cross_x;
    logic [31:0]        cross_y_mag;
    logic               intersects;
  } cci_out_t;

  // Classified job passed from the front end through the queue.
  typedef struct packed {
    logic [64:0] mag;
    logic [64:0] two_ar;
    logic [32:0] dvs;
    logic        neg;
    logic        ok;
  } cci_job_t;

  // State carried through the root and divider stages of the back end.
  typedef struct packed {
    logic [131:0] rad;
    logic [67:0]  rem;
    logic [65:0]  root;
    logic [64:0]  xrem;
    logic [31:0]  q;
    logic [65:0]  yrem;
    logic [31:0]  y;
    logic [32:0]  dvs;
    logic         neg;
    logic         ok;
  } cci_rt_t;

endpackage
`default_nettype wire

### sv/cci_front.sv
// Front end: accepts query words, forms the squares and classifies them.
// Depends on cci_pkg.
`default_nettype none
module cci_front import cci_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     query_valid,
  output logic          query_ready,
  input  wire cci_in_t  query,
  output logic          push_valid,
  input  wire logic     push_ready,
  output cci_job_t      push
);

  logic        en;
  logic        f1_valid, f2_valid, f3_valid;
  logic [63:0] aa, rr, bb, ar;
  logic [31:0] a1;
  logic        nz1, nz2;
  logic [65:0] sd;
  logic [64:0] two_ar2;
  logic [32:0] dvs2;
  logic [64:0] mag_next;
  logic        neg_next;
  cci_job_t    job;

  assign en          = !(f3_valid && !push_ready);
  assign query_ready = en;
  assign push_valid  = f3_valid;
  assign push        = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= query_valid;
      f2_valid <= f1_valid;
      f3_valid <= f2_valid;
    end
  end

  assign neg_next = sd[65];
  assign mag_next = neg_next ? 65'(-sd) : sd[64:0];

  always_ff @(posedge clk) begin
    if (en) begin
      aa  <= 64'(query.center_offset) * 64'(query.center_offset);
      rr  <= 64'(query.origin_radius) * 64'(query.origin_radius);
      bb  <= 64'(query.second_radius) * 64'(query.second_radius);
      ar  <= 64'(query.center_offset) * 64'(query.origin_radius);
      a1  <= query.center_offset;
      nz1 <= (|query.origin_radius) && (|query.center_offset) && (|query.second_radius);
      sd      <= {2'b00, aa} + {2'b00, rr} - {2'b00, bb};
      two_ar2 <= {ar, 1'b0};
      dvs2    <= {a1, 1'b0};
      nz2     <= nz1;
      job.mag    <= mag_next;
      job.neg    <= neg_next;
      job.two_ar <= two_ar2;
      job.dvs    <= dvs2;
      job.ok     <= nz2 && (mag_next <= two_ar2);
    end
  end

endmodule
`default_nettype wire

### sv/cci_queue.sv
// Short queue of classified jobs between the front and back ends.
// Depends on cci_pkg.
`default_nettype none
module cci_queue import cci_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push_valid,
  output logic          push_ready,
  input  wire cci_job_t push,
  output logic          pop_valid,
  input  wire logic     pop_ready,
  output cci_job_t      pop
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cci_job_t        mem [DEPTH];
  logic [AW-1:0]   wr, rd;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop        = mem[rd];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr <= (wr == AW'(DEPTH - 1)) ? '0 : wr + 1'b1;
      end
      if (do_pop) begin
        rd <= (rd == AW'(DEPTH - 1)) ? '0 : rd + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr] <= push;
    end
  end

endmodule
`default_nettype wire

### sv/cci_back.sv
// Back end: radicand product, square root and the two dividers.
// Depends on cci_pkg.
`default_nettype none
module cci_back import cci_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     pop_valid,
  output logic          pop_ready,
  input  wire cci_job_t pop,
  output logic          result_valid,
  input  wire logic     result_ready,
  output cci_out_t      result
);

  localparam int NST = 98;

  function automatic cci_rt_t step(input int k, input cci_rt_t s);
    cci_rt_t     o;
    logic [67:0] rt, tr;
    logic [64:0] xt;
    logic [65:0] yc, yt;
    o = s;
    if (k < 66) begin
      rt    = {s.rem[65:0], s.rad[131:130]};
      tr    = {1'b0, s.root[64:0], 2'b01};
      o.rad = {s.rad[129:0], 2'b00};
      if (rt >= tr) begin
        o.rem  = rt - tr;
        o.root = {s.root[64:0], 1'b1};
      end else begin
        o.rem  = rt;
        o.root = {s.root[64:0], 1'b0};
      end
    end
    if (k < 32) begin
      xt = {32'b0, s.dvs} << (31 - k);
      if (s.xrem >= xt) begin
        o.xrem = s.xrem - xt;
        o.q    = {s.q[30:0], 1'b1};
      end else begin
        o.q    = {s.q[30:0], 1'b0};
      end
    end
    if (k >= 66) begin
      yc = (k == 66) ? s.root : s.yrem;
      yt = {33'b0, s.dvs} << (97 - k);
      if (yc >= yt) begin
        o.yrem = yc - yt;
        o.y    = {s.y[30:0], 1'b1};
      end else begin
        o.yrem = yc;
        o.y    = {s.y[30:0], 1'b0};
      end
    end
    return o;
  endfunction

  logic        en;
  logic        b0_valid, b1_valid, b2_valid;
  logic [65:0] u, v;
  logic [65:0] p_hh, p_hl, p_lh, p_ll;
  logic [66:0] mid;
  logic [65:0] hh2, ll2;
  cci_job_t    s0, s1, s2;
  logic        sv [NST+1];
  cci_rt_t     st [NST+1];
  logic        res_valid;
  cci_out_t    res;

  assign en           = !(res_valid && !result_ready);
  assign pop_ready    = en;
  assign result_valid = res_valid;
  assign result       = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_valid  <= 1'b0;
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      sv[0]     <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      b0_valid  <= pop_valid;
      b1_valid  <= b0_valid;
      b2_valid  <= b1_valid;
      sv[0]     <= b2_valid;
      res_valid <= sv[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u  <= {1'b0, pop.two_ar} - {1'b0, pop.mag};
      v  <= {1'b0, pop.two_ar} + {1'b0, pop.mag};
      s0 <= pop;
      p_hh <= 66'(u[65:33]) * 66'(v[65:33]);
      p_hl <= 66'(u[65:33]) * 66'(v[32:0]);
      p_lh <= 66'(u[32:0]) * 66'(v[65:33]);
      p_ll <= 66'(u[32:0]) * 66'(v[32:0]);
      s1   <= s0;
      mid  <= {1'b0, p_hl} + {1'b0, p_lh};
      hh2  <= p_hh;
      ll2  <= p_ll;
      s2   <= s1;
      st[0].rad  <= {hh2, ll2} + {32'b0, mid, 33'b0};
      st[0].rem  <= '0;
      st[0].root <= '0;
      st[0].xrem <= s2.mag;
      st[0].q    <= '0;
      st[0].yrem <= '0;
      st[0].y    <= '0;
      st[0].dvs  <= s2.dvs;
      st[0].neg  <= s2.neg;
      st[0].ok   <= s2.ok;
      res.intersects  <= st[NST].ok;
      res.cross_y_mag <= st[NST].ok ? st[NST].y : '0;
      if (!st[NST].ok) begin
        res.cross_x <= '0;
      end else if (st[NST].neg) begin
        res.cross_x <= -$signed({1'b0, st[NST].q});
      end else begin
        res.cross_x <= $signed({1'b0, st[NST].q});
      end
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (en) begin
        sv[k+1] <= sv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1] <= step(k, st[k]);
      end
    end
  end

endmodule
`default_nettype wire

### sv/circle_circle_intersection.sv
// Top level of the circle-circle intersection block.
// Depends on cci_pkg, cci_front, cci_queue and cci_back.
//
//   port group    dir  handshake                     word
//   query         in   query_valid / query_ready     cci_in_t
//   result        out  result_valid / result_ready   cci_out_t
//
// One word is accepted per cycle when nothing stalls.
// A result word passes three front stages, one queue slot, four product stages,
// 66 root stages (the first 32 also divide for cross_x) and 32 divider stages.
// The front end and back end stall separately; the queue between them absorbs
// the difference, and a held result freezes the back end, the front end only once the queue is full.
// Reset clears all valid flags and the queue pointers and count.
`default_nettype none
module circle_circle_intersection import cci_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     query_valid,
  output logic          query_ready,
  input  wire cci_in_t  query,
  output logic          result_valid,
  input  wire logic     result_ready,
  output cci_out_t      result
);

  logic     push_valid, push_ready, pop_valid, pop_ready;
  cci_job_t push, pop;

  cci_front u_front (
    .clk, .rst, .query_valid, .query_ready, .query,
    .push_valid, .push_ready, .push
  );

  cci_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .push_valid, .push_ready, .push,
    .pop_valid, .pop_ready, .pop
  );

  cci_back u_back (
    .clk, .rst, .pop_valid, .pop_ready, .pop,
    .result_valid, .result_ready, .result
  );

endmodule
`default_nettype wire

### sv/cci_chk.sv
// Port-level checker for the circle-circle intersection block, with its bind.
// Depends on cci_pkg.
`default_nettype none
module cci_chk import cci_pkg::*; (
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     result_valid,
  input wire logic     result_ready,
  input wire cci_out_t result
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.intersects |-> result.cross_x == 0 && result.cross_y_mag == 0)
    else $error("non-intersecting result has nonzero coordinates");

  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind circle_circle_intersection cci_chk u_chk (
  .clk(clk), .rst(rst), .result_valid(result_valid),
  .result_ready(result_ready), .result(result)
);
`default_nettype wire

### tb/tb.sv
// Testbench for circle_circle_intersection: directed table, then random queries.
// Depends on cci_pkg; results are checked in order against the table or an exact predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import cci_pkg::*;

  typedef struct {
    cci_in_t  q;
    bit       fixed;
    cci_out_t r;
  } row_t;

  logic     clk = 0;
  logic     rst = 1;
  logic     query_valid = 0;
  logic     query_ready;
  cci_in_t  query = '0;
  logic     result_valid;
  logic     result_ready = 0;
  cci_out_t result;

  cci_out_t pending_points[$];
  row_t     rows[$];
  int       errors = 0;
  int       words_in = 0;
  int       quiet_cycles = 0;
  bit       calm = 0;
  bit       hold_done = 0;

  circle_circle_intersection DUT (
    .clk(clk), .rst(rst), .query_valid(query_valid), .query_ready(query_ready),
    .query(query), .result_valid(result_valid), .result_ready(result_ready),
    .result(result)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic cci_out_t predict_crossing(cci_in_t w);
    logic [199:0] r, a, b, wd, sum, bb, mag, nn, dd, rdd, lhs, c;
    logic         neg;
    logic [31:0]  qx, yy;
    cci_out_t     o;
    o = '0;
    r = w.origin_radius;
    a = w.center_offset;
    b = w.second_radius;
    if (r == 0 || a == 0 || b == 0) return o;
    wd = a << 1;
    sum = a * a + r * r;
    bb = b * b;
    neg = sum < bb;
    mag = neg ? bb - sum : sum - bb;
    nn = mag * mag;
    dd = wd * wd;
    rdd = r * r * dd;
    if (nn > rdd) return o;
    qx = 32'(mag / wd);
    yy = 0;
    for (int i = 31; i >= 0; i--) begin
      c = yy | (32'd1 << i);
      lhs = c * c * dd + nn;
      if (lhs <= rdd) yy = 32'(c);
    end
    o.cross_x = neg ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    o.cross_y_mag = yy;
    o.intersects = 1;
    return o;
  endfunction

  function automatic cci_in_t make_query(logic [31:0] r, logic [31:0] a, logic [31:0] b);
    cci_in_t w;
    w.origin_radius = r;
    w.center_offset = a;
    w.second_radius = b;
    return w;
  endfunction

  function automatic cci_in_t random_query();
    logic [31:0] r, b, lo, hi, a;
    int          kind;
    kind = $urandom_range(0, 9);
    if (kind < 2) return make_query($urandom, $urandom, $urandom);
    if (kind < 4) return make_query($urandom_range(0, 300), $urandom_range(0, 300),
                                    $urandom_range(0, 300));
    r = (kind < 7) ? $urandom >> $urandom_range(0, 31) : $urandom;
    b = (kind < 7) ? $urandom >> $urandom_range(0, 31) : $urandom;
    if (r == 0) r = 1;
    if (b == 0) b = 1;
    lo = (r > b) ? r - b : b - r;
    hi = ({1'b0, r} + b > 33'hFFFFFFFF) ? 32'hFFFFFFFF : r + b;
    if (lo == 0) lo = 1;
    a = lo + 32'(({$urandom, $urandom}) % (64'(hi) - lo + 1));
    return make_query(r, a, b);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic offer_word(cci_in_t w, bit fixed, cci_out_t want);
    query_valid <= 1;
    query <= w;
    @(posedge clk);
    while (!query_ready) @(posedge clk);
    pending_points.push_back(fixed ? want : predict_crossing(w));
    words_in++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      query_valid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    cci_out_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected word", result.cross_x, 0);
      end else begin
        want = pending_points.pop_front();
        if (result.cross_x !== want.cross_x)
          report_mismatch("cross_x", result.cross_x, want.cross_x);
        if (result.cross_y_mag !== want.cross_y_mag)
          report_mismatch("cross_y_mag", result.cross_y_mag, want.cross_y_mag);
        if (result.intersects !== want.intersects)
          report_mismatch("intersects", result.intersects, want.intersects);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (query_valid && query_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_done && words_in >= 300) begin
        hold_done = 1;
        result_ready <= 0;
        repeat (1000) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        result_ready <= 0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        result_ready <= 1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    cci_out_t none;
    none = '0;
    rows.push_back('{make_query(0, 5, 5), 1, none});
    rows.push_back('{make_query(5, 0, 5), 1, none});
    rows.push_back('{make_query(5, 5, 0), 1, none});
    rows.push_back('{make_query(0, 0, 0), 1, none});
    rows.push_back('{make_query(1, 100, 1), 1, none});
    rows.push_back('{make_query(100, 1, 1), 1, none});
    rows.push_back('{make_query(1, 1, 100), 1, none});
    rows.push_back('{make_query(32'h10000, 32'h20000, 32'h10000), 1,
                     '{33'sh10000, 32'h0, 1'b1}});
    rows.push_back('{make_query(32'h20000, 32'h10000, 32'h10000), 1,
                     '{33'sh20000, 32'h0, 1'b1}});
    rows.push_back('{make_query(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF), 0, none});
    rows.push_back('{make_query(1, 1, 1), 0, none});
    rows.push_back('{make_query(32'h30000, 32'h50000, 32'h40000), 0, none});
    rows.push_back('{make_query(32'h10000, 32'h10000, 32'h18000), 0, none});
    rows.push_back('{make_query(32'hFFFFFFFF, 32'h1, 32'hFFFFFFFF), 0, none});
    rows.push_back('{make_query(32'h1, 32'hFFFFFFFF, 32'hFFFFFFFF), 0, none});
    rows.push_back('{make_query(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h1), 0, none});
    rows.push_back('{make_query(32'h7FFFFFFF, 32'hFFFFFFFF, 32'h80000000), 1,
                     '{33'sh7FFFFFFF, 32'h0, 1'b1}});
    rows.push_back('{make_query(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA), 0, none});
    rows.push_back('{make_query(32'h55555555, 32'hAAAAAAAA, 32'h55555555), 0, none});

    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (rows[i]) offer_word(rows[i].q, rows[i].fixed, rows[i].r);
    for (int n = 0; n < 1100; n++) begin
      if (n == 600) begin
        query_valid <= 0;
        while (pending_points.size() != 0) @(posedge clk);
      end
      if (n == 950) calm = 1;
      offer_word(random_query(), 0, none);
    end
    query_valid <= 0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
sv/cci_pkg.sv
sv/cci_front.sv
sv/cci_queue.sv
sv/cci_back.sv
sv/circle_circle_intersection.sv
sv/cci_chk.sv
tb/tb.sv
